FILE: src/nbs_pkg.sv
`timescale 1ns / 1ps
// Package for the bitmask suppression block: field widths, defaults and the
// packed word types shared by the front, the queues, the back and the top level.
// Depends on nothing.
package nbs_pkg;

    // Field widths fixed by the interface.
    localparam int ROW_W       = 12;
    localparam int WORD_IDX_W  = 6;
    localparam int MASK_W      = 64;
    localparam int BOX_COUNT_W = 13;
    localparam int KEPT_W      = 13;

    // Parameter defaults. WORD_BITS must be a power of two.
    localparam int MAX_BOXES_DEF = 4096;
    localparam int WORD_BITS_DEF = 64;

    // Register reset value and counter ceiling.
    localparam logic [BOX_COUNT_W-1:0] BOX_COUNT_RESET = 13'd4096;
    localparam logic [KEPT_W-1:0]      KEPT_MAX        = 13'd8191;

    // Depth of the queue between front and back and of the result queue.
    localparam int FIFO_DEPTH = 4;

    // One input word.
    typedef struct packed {
        logic [ROW_W-1:0]      row_index;
        logic [WORD_IDX_W-1:0] word_index;
        logic [MASK_W-1:0]     mask_word;
    } t_in_item;

    // One result word.
    typedef struct packed {
        logic [ROW_W-1:0]  box_index;
        logic              kept;
        logic [KEPT_W-1:0] kept_total;
        logic              last_box;
    } t_result;

    // Classified operation handed from the front to the back.
    typedef struct packed {
        logic                  start;    // first word of a row: decide the box
        logic                  clear;    // row 0 begins: empty the store first
        logic                  last;     // box is the last of the run
        logic                  rd_ok;    // addressed store word exists
        logic                  in_span;  // word may be ORed into the store
        logic [ROW_W-1:0]      row;
        logic [WORD_IDX_W-1:0] addr;     // store word to read and update
        logic [WORD_IDX_W-1:0] bit_idx;  // box bit inside its own word
        logic [MASK_W-1:0]     bits;
    } t_op;

endpackage

FILE: src/nbs_fifo.sv
`timescale 1ns / 1ps
// Small register queue with push/pop handshakes and an occupancy count.
// Depends on nothing; the word type and depth (a power of two) come in as parameters.
module nbs_fifo #(
    parameter int  DEPTH = 4,
    parameter type t_data = logic
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_data                      i_data,
    input  logic                       i_pop,
    output t_data                      o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           w_do_push;
    logic           w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: src/nbs_front.sv
`timescale 1ns / 1ps
// Front of the suppression block: holds the box count register, drops words that
// do nothing, and turns the rest into operations for the back. Uses nbs_pkg.
module nbs_front #(
    parameter int MAX_BOXES = nbs_pkg::MAX_BOXES_DEF,
    parameter int WORD_BITS = nbs_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nbs_pkg::BOX_COUNT_W-1:0]     i_cfg_wdata,
    input  logic                                i_accept,
    input  nbs_pkg::t_in_item                   i_item,
    output logic                                o_op_push,
    output nbs_pkg::t_op                        o_op
);

    localparam int WB_LOG      = $clog2(WORD_BITS);
    localparam int STORE_WORDS = (MAX_BOXES + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_SPAN    = 2 ** nbs_pkg::WORD_IDX_W;
    localparam int MEM_WORDS   = (STORE_WORDS < IDX_SPAN) ? STORE_WORDS : IDX_SPAN;
    localparam int MAXB_W      = $clog2(MAX_BOXES + 1);
    localparam int CNT_W       = (MAXB_W > nbs_pkg::BOX_COUNT_W) ? MAXB_W
                                                                  : nbs_pkg::BOX_COUNT_W;

    logic [nbs_pkg::BOX_COUNT_W-1:0] r_box_count;
    logic [nbs_pkg::ROW_W-1:0]       r_cur_row;
    logic                            r_row_valid;

    logic [CNT_W-1:0]                w_count_ext;
    logic [CNT_W-1:0]                w_eff_count;
    logic [CNT_W-1:0]                w_row_ext;
    logic [nbs_pkg::ROW_W-1:0]       w_own_word;
    logic [nbs_pkg::ROW_W-1:0]       w_word_ext;
    logic [31:0]                     w_word_base;
    logic                            w_start;
    logic                            w_in_range;
    logic                            w_stray;
    logic                            w_word_in_mem;
    logic                            w_own_in_mem;

    // Effective box count, clamped to one through MAX_BOXES.
    always_comb begin
        w_count_ext = CNT_W'(r_box_count);
        if (r_box_count == '0) begin
            w_eff_count = CNT_W'(1);
        end else if (w_count_ext > CNT_W'(MAX_BOXES)) begin
            w_eff_count = CNT_W'(MAX_BOXES);
        end else begin
            w_eff_count = w_count_ext;
        end
    end

    // Classify the word.
    always_comb begin
        w_row_ext     = CNT_W'(i_item.row_index);
        w_own_word    = i_item.row_index >> WB_LOG;
        w_word_ext    = nbs_pkg::ROW_W'(i_item.word_index);
        w_word_base   = 32'(i_item.word_index) * 32'(WORD_BITS);
        w_start       = (i_item.word_index == '0);
        w_in_range    = (w_row_ext < w_eff_count);
        w_stray       = !w_start && (!r_row_valid || (i_item.row_index != r_cur_row));
        w_word_in_mem = (32'(i_item.word_index) < 32'(MEM_WORDS));
        w_own_in_mem  = (32'(w_own_word) < 32'(MEM_WORDS));
    end

    // Build the operation for the back.
    always_comb begin
        o_op_push       = i_accept && w_in_range && !w_stray;
        o_op.start      = w_start;
        o_op.clear      = w_start && (i_item.row_index == '0);
        o_op.last       = (w_row_ext == (w_eff_count - 1'b1));
        o_op.rd_ok      = w_start ? w_own_in_mem : w_word_in_mem;
        o_op.in_span    = (w_word_ext >= w_own_word) && w_word_in_mem
                          && (w_word_base < 32'(w_eff_count));
        o_op.row        = i_item.row_index;
        o_op.addr       = w_start ? w_own_word[nbs_pkg::WORD_IDX_W-1:0] : i_item.word_index;
        o_op.bit_idx    = nbs_pkg::WORD_IDX_W'(i_item.row_index[WB_LOG-1:0]);
        o_op.bits       = i_item.mask_word;
    end

    // Configuration register and the row most recently begun.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count <= nbs_pkg::BOX_COUNT_RESET;
            r_cur_row   <= '0;
            r_row_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_box_count <= i_cfg_wdata;
            end
            if (i_accept && w_in_range && w_start) begin
                r_cur_row   <= i_item.row_index;
                r_row_valid <= 1'b1;
            end
        end
    end

endmodule

FILE: src/nbs_back.sv
`timescale 1ns / 1ps
// Back of the suppression block: the removed-bit store with its valid bits, the
// keep decision, the kept counter and the result queue. Uses nbs_pkg and nbs_fifo.
module nbs_back #(
    parameter int MAX_BOXES = nbs_pkg::MAX_BOXES_DEF,
    parameter int WORD_BITS = nbs_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_empty,
    input  nbs_pkg::t_op      i_op,
    output logic              o_op_pop,
    output logic              o_res_empty,
    input  logic              i_res_pop,
    output nbs_pkg::t_result  o_result
);

    localparam int STORE_WORDS = (MAX_BOXES + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_SPAN    = 2 ** nbs_pkg::WORD_IDX_W;
    localparam int MEM_WORDS   = (STORE_WORDS < IDX_SPAN) ? STORE_WORDS : IDX_SPAN;
    localparam int AW          = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int FCW         = $clog2(nbs_pkg::FIFO_DEPTH + 1);

    // Store, its valid bits and the registered read.
    logic [WORD_BITS-1:0]        r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0]        r_valid;
    logic [WORD_BITS-1:0]        r_rd_data;

    // Operation in the decide stage.
    logic                        r_b_valid;
    nbs_pkg::t_op                r_b;

    // Last write, forwarded to the next operation.
    logic                        r_wr_en;
    logic [AW-1:0]               r_wr_addr;
    logic [WORD_BITS-1:0]        r_wr_data;

    logic                        r_kept;
    logic [nbs_pkg::KEPT_W-1:0]  r_kept_cnt;

    logic [AW-1:0]               w_addr;
    logic [WORD_BITS-1:0]        w_cur;
    logic                        w_kept_now;
    logic                        w_wr_en;
    logic [WORD_BITS-1:0]        w_wr_data;
    logic [nbs_pkg::KEPT_W-1:0]  w_cnt_base;
    logic [nbs_pkg::KEPT_W-1:0]  n_kept_cnt;
    logic                        w_res_push;
    nbs_pkg::t_result            w_res;
    logic [FCW-1:0]              w_res_count;
    logic [FCW:0]                w_res_need;

    // Take the next operation only when the result queue has room for it and
    // for the one already in the decide stage.
    assign w_res_need = (FCW + 1)'(w_res_count) + (FCW + 1)'(r_b_valid && r_b.start);
    assign o_op_pop   = !i_op_empty && (w_res_need < (FCW + 1)'(nbs_pkg::FIFO_DEPTH));

    // Current store word with forwarding of the write made as it was read.
    always_comb begin
        w_addr = r_b.addr[AW-1:0];
        if (r_b.clear || !r_b.rd_ok) begin
            w_cur = '0;
        end else if (r_wr_en && (r_wr_addr == w_addr)) begin
            w_cur = r_wr_data;
        end else if (r_valid[w_addr]) begin
            w_cur = r_rd_data;
        end else begin
            w_cur = '0;
        end
    end

    // Keep decision, store update and kept count.
    always_comb begin
        w_kept_now = r_b.start ? !w_cur[r_b.bit_idx[$clog2(WORD_BITS)-1:0]] : r_kept;
        w_wr_en    = r_b_valid && w_kept_now && r_b.in_span && r_b.rd_ok;
        w_wr_data  = w_cur | r_b.bits[WORD_BITS-1:0];
        w_cnt_base = r_b.clear ? '0 : r_kept_cnt;
        n_kept_cnt = w_cnt_base;
        if (w_kept_now && (w_cnt_base < nbs_pkg::KEPT_MAX)) begin
            n_kept_cnt = w_cnt_base + 1'b1;
        end
        w_res_push          = r_b_valid && r_b.start;
        w_res.box_index     = r_b.row;
        w_res.kept          = w_kept_now;
        w_res.kept_total    = n_kept_cnt;
        w_res.last_box      = r_b.last;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_wr_en    <= 1'b0;
            r_kept     <= 1'b0;
            r_kept_cnt <= '0;
            r_valid    <= '0;
        end else begin
            r_b_valid <= o_op_pop;
            r_wr_en   <= w_wr_en;
            if (w_res_push) begin
                r_kept     <= w_kept_now;
                r_kept_cnt <= n_kept_cnt;
            end
            // A clearing row leaves only the word it writes itself valid.
            if (r_b_valid && r_b.clear) begin
                r_valid <= w_wr_en ? (MEM_WORDS'(1) << w_addr) : '0;
            end else if (w_wr_en) begin
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    // Payload registers and the store.
    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_b       <= i_op;
            r_rd_data <= r_mem[i_op.addr[AW-1:0]];
        end
        r_wr_addr <= w_addr;
        r_wr_data <= w_wr_data;
        if (w_wr_en) begin
            r_mem[w_addr] <= w_wr_data;
        end
    end

    // Result queue toward the consumer.
    nbs_fifo #(
        .DEPTH  (nbs_pkg::FIFO_DEPTH),
        .t_data (nbs_pkg::t_result)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (i_res_pop),
        .o_data  (o_result),
        .o_full  (),
        .o_empty (o_res_empty),
        .o_count (w_res_count)
    );

endmodule

FILE: src/nms_bitmask_suppression.sv
`timescale 1ns / 1ps
// Top level of the greedy bitmask suppression block.
// Uses nbs_pkg, nbs_front, nbs_fifo and nbs_back.
//
// Usage:
//   Input channel: overlap-mask words (row, word index, 64-bit mask) are pushed
//   with push while full is low. Rows come in box order, words of a row in
//   ascending order. Words of rows at or past the box count, and words that do
//   not belong to the row most recently begun, are dropped at the front.
//   Result channel: one result per row, made on the row's first word. The oldest
//   result is shown while empty is low and leaves on pop.
//   Configuration: i_cfg_we writes the box count at once; write it only while
//   no word is in flight.
//   Throughput: one mask word per cycle unless stalled. Each does one read-modify-write of
//   the 64-word removed-bit store; the write is forwarded to the next word.
//   Path: words pass the front-to-back queue, then the decide stage register.
//   Stalls: a four-word queue sits between front and back and another holds
//   results; when the consumer stops popping they fill and full rises.
//   Reset: the box count returns to 4096, the store's valid bits, the kept
//   count and both queues are cleared. Row 0 clears the store and the count too.
module nms_bitmask_suppression #(
    parameter int MAX_BOXES = nbs_pkg::MAX_BOXES_DEF,
    parameter int WORD_BITS = nbs_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  nbs_pkg::t_in_item               i_item,
    output logic                            empty,
    input  logic                            pop,
    output nbs_pkg::t_result                o_result,
    input  logic                            i_cfg_we,
    input  logic [nbs_pkg::BOX_COUNT_W-1:0] i_cfg_wdata
);

    logic          w_accept;
    logic          w_op_push;
    nbs_pkg::t_op  w_op_in;
    nbs_pkg::t_op  w_op_out;
    logic          w_op_pop;
    logic          w_op_empty;

    assign w_accept = push && !full;

    // Front: configuration and classification.
    nbs_front #(
        .MAX_BOXES (MAX_BOXES),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .o_op_push   (w_op_push),
        .o_op        (w_op_in)
    );

    // Queue between front and back.
    nbs_fifo #(
        .DEPTH  (nbs_pkg::FIFO_DEPTH),
        .t_data (nbs_pkg::t_op)
    ) u_op_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_push),
        .i_data  (w_op_in),
        .i_pop   (w_op_pop),
        .o_data  (w_op_out),
        .o_full  (full),
        .o_empty (w_op_empty),
        .o_count ()
    );

    // Back: store, decision and results.
    nbs_back #(
        .MAX_BOXES (MAX_BOXES),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_empty  (w_op_empty),
        .i_op        (w_op_out),
        .o_op_pop    (w_op_pop),
        .o_res_empty (empty),
        .i_res_pop   (pop),
        .o_result    (o_result)
    );

endmodule

FILE: src/nbs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the suppression block, attached to the top level by bind.
// Uses nbs_pkg.
module nbs_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input nbs_pkg::t_result o_result
);

    // Reset leaves both queues empty.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // A shown result holds until it is popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("result changed before pop");

    // Box 0 always survives and restarts the kept count.
    a_box0_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result.box_index == '0) |-> o_result.kept
            && (o_result.kept_total == nbs_pkg::KEPT_W'(1)))
        else $error("box 0 not kept as first");

    // A kept box is always counted.
    a_kept_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.kept |-> (o_result.kept_total != '0))
        else $error("kept box with zero total");

endmodule

bind nms_bitmask_suppression nbs_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
